### hdl/edsd_pkg.sv
package edsd_pkg;

    localparam int MAX_SCALAR_BYTES = 66;
    localparam int STORE_DEPTH      = 2 * MAX_SCALAR_BYTES;
    localparam int ADDR_W           = $clog2(STORE_DEPTH);

    localparam logic       OP_PUSH = 1'b0;
    localparam logic       OP_READ = 1'b1;

    localparam logic [1:0] ST_BUSY   = 2'd0;
    localparam logic [1:0] ST_ACCEPT = 2'd1;
    localparam logic [1:0] ST_REJECT = 2'd2;

    typedef logic [ADDR_W-1:0] addr_t;

    // per-item command from the parser to the store and output stages
    typedef struct packed {
        logic       wr_en;
        addr_t      wr_addr;
        logic [7:0] wr_data;
        logic       rd_en;
        addr_t      rd_addr;
        logic [1:0] status;
        logic       read_ok;
        logic       pad_zero;
    } edsd_cmd_t;

endpackage

### hdl/edsd_parser.sv
module edsd_parser (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               fire,
    input  logic               opcode,
    input  logic [7:0]         der_byte,
    input  logic               last_byte,
    input  logic [7:0]         raw_index,
    input  logic               cfg_fire,
    input  logic [6:0]         cfg_scalar_size,
    output edsd_pkg::edsd_cmd_t cmd
);
    import edsd_pkg::*;

    localparam logic [3:0] PH_SEQ_TAG        = 4'd0;
    localparam logic [3:0] PH_SEQ_LEN        = 4'd1;
    localparam logic [3:0] PH_SEQ_LEN_EXT    = 4'd2;
    localparam logic [3:0] PH_INT_TAG        = 4'd3;
    localparam logic [3:0] PH_INT_LEN        = 4'd4;
    localparam logic [3:0] PH_INT_LEN_EXT    = 4'd5;
    localparam logic [3:0] PH_INT_FIRST      = 4'd6;
    localparam logic [3:0] PH_INT_AFTER_ZERO = 4'd7;
    localparam logic [3:0] PH_INT_BODY       = 4'd8;
    localparam logic [3:0] PH_DONE           = 4'd9;

    localparam logic [8:0] BAH_MAX = 9'd511;
    localparam logic [7:0] DEPTH8  = 8'(STORE_DEPTH);
    localparam logic [6:0] MAX7    = 7'(MAX_SCALAR_BYTES);

    logic [6:0] scalar_reg;
    logic [3:0] phase_reg, phase_next;
    logic [8:0] bah_reg, bah_next;
    logic [7:0] seq_len_reg, seq_len_next;
    logic [7:0] ibl_reg, ibl_next;
    logic       second_reg, second_next;
    logic       failed_reg, failed_next;
    logic [6:0] vstart0_reg, vstart0_next;
    logic [6:0] vstart1_reg, vstart1_next;
    logic       store_valid_reg, store_valid_next;

    logic       scalar_ok;
    logic [7:0] size8;
    logic [7:0] base8;
    logic [7:0] val_addr;
    logic       take_byte;
    logic       set_pad;
    logic [7:0] pad_len;
    logic       msg_ok;
    logic       rd_half;
    logic [7:0] rd_off;
    logic [6:0] rd_vstart;
    logic       rd_in_range;

    assign size8     = {1'b0, scalar_reg};
    assign scalar_ok = (scalar_reg != 7'd0) && (scalar_reg <= MAX7);
    assign base8     = second_reg ? size8 : 8'd0;
    assign val_addr  = base8 + size8 - ibl_reg;

    assign rd_half     = raw_index >= size8;
    assign rd_off      = raw_index - (rd_half ? size8 : 8'd0);
    assign rd_vstart   = rd_half ? vstart1_reg : vstart0_reg;
    assign rd_in_range = (raw_index < {scalar_reg, 1'b0}) && (raw_index < DEPTH8);

    always_comb
    begin
        phase_next       = phase_reg;
        bah_next         = bah_reg;
        seq_len_next     = seq_len_reg;
        ibl_next         = ibl_reg;
        second_next      = second_reg;
        failed_next      = failed_reg;
        vstart0_next     = vstart0_reg;
        vstart1_next     = vstart1_reg;
        store_valid_next = store_valid_reg;
        take_byte        = 1'b0;
        set_pad          = 1'b0;
        pad_len          = ibl_reg;
        msg_ok           = 1'b0;

        cmd          = '0;
        cmd.wr_data  = der_byte;
        cmd.wr_addr  = val_addr[ADDR_W-1:0];
        cmd.rd_addr  = raw_index[ADDR_W-1:0];
        cmd.status   = ST_BUSY;

        if (fire && opcode == OP_READ) begin
            cmd.read_ok  = store_valid_reg && rd_in_range;
            cmd.rd_en    = cmd.read_ok;
            cmd.pad_zero = rd_off < {1'b0, rd_vstart};
        end else if (fire) begin
            store_valid_next = 1'b0;
            if (!failed_reg) begin
                if (phase_reg >= PH_INT_TAG && bah_reg < BAH_MAX)
                    bah_next = bah_reg + 9'd1;
                unique case (phase_reg)
                    PH_SEQ_TAG:
                    begin
                        if (!scalar_ok || der_byte != 8'h30) failed_next = 1'b1;
                        else phase_next = PH_SEQ_LEN;
                    end
                    PH_SEQ_LEN:
                    begin
                        if (der_byte < 8'h80) begin
                            seq_len_next = der_byte;
                            phase_next   = PH_INT_TAG;
                        end else if (der_byte == 8'h81) begin
                            phase_next = PH_SEQ_LEN_EXT;
                        end else begin
                            failed_next = 1'b1;
                        end
                    end
                    PH_SEQ_LEN_EXT:
                    begin
                        if (der_byte < 8'd128) begin
                            failed_next = 1'b1;
                        end else begin
                            seq_len_next = der_byte;
                            phase_next   = PH_INT_TAG;
                        end
                    end
                    PH_INT_TAG:
                    begin
                        if (der_byte != 8'h02) failed_next = 1'b1;
                        else phase_next = PH_INT_LEN;
                    end
                    PH_INT_LEN:
                    begin
                        if (der_byte == 8'd0) begin
                            failed_next = 1'b1;
                        end else if (der_byte < 8'h80) begin
                            ibl_next   = der_byte;
                            phase_next = PH_INT_FIRST;
                        end else if (der_byte == 8'h81) begin
                            phase_next = PH_INT_LEN_EXT;
                        end else begin
                            failed_next = 1'b1;
                        end
                    end
                    PH_INT_LEN_EXT:
                    begin
                        if (der_byte < 8'd128) begin
                            failed_next = 1'b1;
                        end else begin
                            ibl_next   = der_byte;
                            phase_next = PH_INT_FIRST;
                        end
                    end
                    PH_INT_FIRST:
                    begin
                        if (der_byte[7]) begin
                            failed_next = 1'b1;
                        end else if (der_byte == 8'd0 && ibl_reg > 8'd1) begin
                            // strip the one allowed leading zero
                            if (ibl_reg - 8'd1 > size8) begin
                                failed_next = 1'b1;
                            end else begin
                                ibl_next   = ibl_reg - 8'd1;
                                pad_len    = ibl_reg - 8'd1;
                                set_pad    = 1'b1;
                                phase_next = PH_INT_AFTER_ZERO;
                            end
                        end else begin
                            if (ibl_reg > size8) begin
                                failed_next = 1'b1;
                            end else begin
                                set_pad   = 1'b1;
                                take_byte = 1'b1;
                            end
                        end
                    end
                    PH_INT_AFTER_ZERO:
                    begin
                        if (!der_byte[7]) failed_next = 1'b1;
                        else take_byte = 1'b1;
                    end
                    PH_INT_BODY:
                    begin
                        take_byte = 1'b1;
                    end
                    default:
                    begin
                        failed_next = 1'b1;
                    end
                endcase

                // padding is not written; reads below value_start return zero
                if (set_pad) begin
                    if (second_reg) vstart1_next = scalar_reg - pad_len[6:0];
                    else vstart0_next = scalar_reg - pad_len[6:0];
                end

                if (take_byte) begin
                    cmd.wr_en = val_addr < DEPTH8;
                    ibl_next  = ibl_reg - 8'd1;
                    if (ibl_reg != 8'd1) begin
                        phase_next = PH_INT_BODY;
                    end else if (!second_reg) begin
                        second_next = 1'b1;
                        phase_next  = PH_INT_TAG;
                    end else begin
                        phase_next = PH_DONE;
                    end
                end
            end

            if (last_byte) begin
                msg_ok = !failed_next && phase_next == PH_DONE
                         && bah_next == {1'b0, seq_len_next};
                cmd.status       = msg_ok ? ST_ACCEPT : ST_REJECT;
                store_valid_next = msg_ok;
                phase_next       = PH_SEQ_TAG;
                bah_next         = 9'd0;
                seq_len_next     = 8'd0;
                ibl_next         = 8'd0;
                second_next      = 1'b0;
                failed_next      = 1'b0;
            end else begin
                cmd.status = failed_next ? ST_REJECT : ST_BUSY;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            scalar_reg      <= 7'd32;
            phase_reg       <= PH_SEQ_TAG;
            bah_reg         <= 9'd0;
            seq_len_reg     <= 8'd0;
            ibl_reg         <= 8'd0;
            second_reg      <= 1'b0;
            failed_reg      <= 1'b0;
            vstart0_reg     <= 7'd0;
            vstart1_reg     <= 7'd0;
            store_valid_reg <= 1'b0;
        end else if (cfg_fire) begin
            // new scalar size: restart the parser and drop the stored signature
            scalar_reg      <= cfg_scalar_size;
            phase_reg       <= PH_SEQ_TAG;
            bah_reg         <= 9'd0;
            seq_len_reg     <= 8'd0;
            ibl_reg         <= 8'd0;
            second_reg      <= 1'b0;
            failed_reg      <= 1'b0;
            store_valid_reg <= 1'b0;
        end else begin
            phase_reg       <= phase_next;
            bah_reg         <= bah_next;
            seq_len_reg     <= seq_len_next;
            ibl_reg         <= ibl_next;
            second_reg      <= second_next;
            failed_reg      <= failed_next;
            vstart0_reg     <= vstart0_next;
            vstart1_reg     <= vstart1_next;
            store_valid_reg <= store_valid_next;
        end
    end

endmodule

### hdl/ecdsa_der_signature_decoder.sv
// Strict DER decoder for ECDSA signatures. Push DER bytes with opcode 0, one per transfer,
// last_byte set on the final one; each push returns a status (in progress, accepted or
// rejected). Read raw r||s bytes with opcode 1; read_ok is set only after an accepted
// message. The block takes one item every cycle while out_ready does not stall the output;
// each result passes through the synchronous read of the 132-byte value store and then the
// output register. The store needs no clearing pass after reset; leading zero padding of
// each scalar is not written but masked on read.
module ecdsa_der_signature_decoder (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       opcode,
    input  logic [7:0] der_byte,
    input  logic       last_byte,
    input  logic [7:0] raw_index,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] status,
    output logic [7:0] raw_byte,
    output logic       read_ok,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [6:0] cfg_scalar_size
);
    import edsd_pkg::*;

    edsd_cmd_t  cmd;
    logic       fire;
    logic       cfg_fire;
    logic       s1_advance;

    logic [7:0] mem_reg [STORE_DEPTH];
    logic [7:0] mem_rdata_reg;

    logic       s1_valid_reg;
    logic [1:0] s1_status_reg;
    logic       s1_ok_reg;
    logic       s1_pad_reg;

    logic       out_valid_reg;
    logic [1:0] status_reg;
    logic [7:0] raw_byte_reg;
    logic       read_ok_reg;

    assign cfg_ready  = 1'b1;
    assign cfg_fire   = cfg_valid && cfg_ready;
    assign s1_advance = !out_valid_reg || out_ready;
    assign in_ready   = !s1_valid_reg || s1_advance;
    assign fire       = in_valid && in_ready;

    edsd_parser u_parser (
        .clk             (clk),
        .rst_n           (rst_n),
        .fire            (fire),
        .opcode          (opcode),
        .der_byte        (der_byte),
        .last_byte       (last_byte),
        .raw_index       (raw_index),
        .cfg_fire        (cfg_fire),
        .cfg_scalar_size (cfg_scalar_size),
        .cmd             (cmd)
    );

    // read data holds while stage 1 stalls, since no new read is issued then
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
            mem_reg[cmd.wr_addr] <= cmd.wr_data;
        if (cmd.rd_en)
            mem_rdata_reg <= mem_reg[cmd.rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s1_valid_reg <= 1'b0;
        end else if (in_ready) begin
            s1_valid_reg <= fire;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire) begin
            s1_status_reg <= cmd.status;
            s1_ok_reg     <= cmd.read_ok;
            s1_pad_reg    <= cmd.pad_zero;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else if (s1_advance) begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance && s1_valid_reg) begin
            status_reg   <= s1_status_reg;
            read_ok_reg  <= s1_ok_reg;
            raw_byte_reg <= (s1_ok_reg && !s1_pad_reg) ? mem_rdata_reg : 8'd0;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign raw_byte  = raw_byte_reg;
    assign read_ok   = read_ok_reg;

endmodule

### tb/sv/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import edsd_pkg::*;

    localparam int QUIET_LIMIT = 3000;
    localparam int ITEM_TARGET = 700;
    localparam int HOLD_CYCLES = 200;

    localparam logic [7:0] TAG_SEQUENCE = 8'h30;
    localparam logic [7:0] TAG_INTEGER  = 8'h02;
    localparam logic [7:0] LEN_LONG_1   = 8'h81;

    // parser position inside the DER message; the order matters for the header count
    typedef enum logic [3:0] {
        WAIT_SEQ_TAG,
        WAIT_SEQ_LEN,
        WAIT_SEQ_LEN_EXT,
        WAIT_INT_TAG,
        WAIT_INT_LEN,
        WAIT_INT_LEN_EXT,
        WAIT_INT_FIRST,
        WAIT_AFTER_ZERO,
        WAIT_INT_BODY,
        SIG_DONE
    } der_phase_e;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] raw;
        logic       ok;
    } reply_t;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic       opcode;
    logic [7:0] der_byte;
    logic       last_byte;
    logic [7:0] raw_index;
    logic       out_valid;
    logic       out_ready;
    logic [1:0] status;
    logic [7:0] raw_byte;
    logic       read_ok;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [6:0] cfg_scalar_size;

    // decoder shadow state
    int unsigned size_cfg;
    der_phase_e  phase;
    int unsigned hdr_count;
    int unsigned seq_len;
    int unsigned int_left;
    bit          second_int;
    bit          failed;
    bit          store_ok;
    logic [7:0]  raw_mem [0:STORE_DEPTH-1];

    reply_t     replies_due[$];
    reply_t     got_want;
    logic [7:0] msg_q[$];
    logic [7:0] body_q[$];

    int mismatches;
    int items_sent;
    int quiet_cycles;
    int hold_request;
    int hold_left;
    bit no_idle;

    ecdsa_der_signature_decoder u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .opcode          (opcode),
        .der_byte        (der_byte),
        .last_byte       (last_byte),
        .raw_index       (raw_index),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .status          (status),
        .raw_byte        (raw_byte),
        .read_ok         (read_ok),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_scalar_size (cfg_scalar_size)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // ---------------------------------------------------------------- decoder shadow

    function automatic void restart_parse();
        phase      = WAIT_SEQ_TAG;
        hdr_count  = 0;
        seq_len    = 0;
        int_left   = 0;
        second_int = 1'b0;
        failed     = 1'b0;
    endfunction

    function automatic void mem_write(int unsigned pos, logic [7:0] v);
        if (pos < STORE_DEPTH)
            raw_mem[pos] = v;
    endfunction

    // zero the left padding of the current scalar
    function automatic void zero_fill(int unsigned len);
        int unsigned base;
        int unsigned i;
        base = second_int ? size_cfg : 0;
        for (i = 0; i < size_cfg - len; i++)
            mem_write(base + i, 8'h00);
    endfunction

    function automatic void take_value(logic [7:0] b);
        int unsigned base;
        base = second_int ? size_cfg : 0;
        mem_write(base + size_cfg - int_left, b);
        int_left--;
        if (int_left != 0)
            phase = WAIT_INT_BODY;
        else if (!second_int)
        begin
            second_int = 1'b1;
            phase      = WAIT_INT_TAG;
        end
        else
            phase = SIG_DONE;
    endfunction

    function automatic void parse_der(logic [7:0] b);
        bit size_ok;
        size_ok = size_cfg >= 1 && size_cfg <= MAX_SCALAR_BYTES;
        if (phase >= WAIT_INT_TAG && hdr_count < 511)
            hdr_count++;
        case (phase)
            WAIT_SEQ_TAG:
                if (!size_ok || b != TAG_SEQUENCE) failed = 1'b1;
                else phase = WAIT_SEQ_LEN;
            WAIT_SEQ_LEN:
                if (b < 8'h80)
                begin
                    seq_len = b;
                    phase   = WAIT_INT_TAG;
                end
                else if (b == LEN_LONG_1) phase = WAIT_SEQ_LEN_EXT;
                else failed = 1'b1;
            WAIT_SEQ_LEN_EXT:
                if (b < 8'h80) failed = 1'b1;
                else
                begin
                    seq_len = b;
                    phase   = WAIT_INT_TAG;
                end
            WAIT_INT_TAG:
                if (b != TAG_INTEGER) failed = 1'b1;
                else phase = WAIT_INT_LEN;
            WAIT_INT_LEN:
                if (b == 8'h00) failed = 1'b1;
                else if (b < 8'h80)
                begin
                    int_left = b;
                    phase    = WAIT_INT_FIRST;
                end
                else if (b == LEN_LONG_1) phase = WAIT_INT_LEN_EXT;
                else failed = 1'b1;
            WAIT_INT_LEN_EXT:
                if (b < 8'h80) failed = 1'b1;
                else
                begin
                    int_left = b;
                    phase    = WAIT_INT_FIRST;
                end
            WAIT_INT_FIRST:
                if (b[7])
                    failed = 1'b1;
                else if (b == 8'h00 && int_left > 1)
                begin
                    // one leading zero is allowed, the value after it must be negative-looking
                    if (int_left - 1 > size_cfg) failed = 1'b1;
                    else
                    begin
                        int_left--;
                        zero_fill(int_left);
                        phase = WAIT_AFTER_ZERO;
                    end
                end
                else
                begin
                    if (int_left > size_cfg) failed = 1'b1;
                    else
                    begin
                        zero_fill(int_left);
                        take_value(b);
                    end
                end
            WAIT_AFTER_ZERO:
                if (!b[7]) failed = 1'b1;
                else take_value(b);
            WAIT_INT_BODY:
                take_value(b);
            default:
                failed = 1'b1;
        endcase
    endfunction

    function automatic reply_t decode_push(logic [7:0] b, logic last);
        reply_t r;
        r.status = ST_BUSY;
        r.raw    = 8'h00;
        r.ok     = 1'b0;
        store_ok = 1'b0;
        if (!failed)
            parse_der(b);
        if (last)
        begin
            if (!failed && phase == SIG_DONE && hdr_count == seq_len)
            begin
                r.status = ST_ACCEPT;
                store_ok = 1'b1;
            end
            else
                r.status = ST_REJECT;
            restart_parse();
        end
        else if (failed)
            r.status = ST_REJECT;
        return r;
    endfunction

    function automatic reply_t fetch_raw(logic [7:0] idx);
        reply_t r;
        r.status = ST_BUSY;
        r.raw    = 8'h00;
        r.ok     = 1'b0;
        if (store_ok && idx < 2 * size_cfg && idx < STORE_DEPTH)
        begin
            r.raw = raw_mem[idx];
            r.ok  = 1'b1;
        end
        return r;
    endfunction

    // ---------------------------------------------------------------- message builder

    function automatic void add_integer(int vlen, bit hi);
        int n;
        int i;
        n = vlen + (hi ? 1 : 0);
        body_q.push_back(TAG_INTEGER);
        body_q.push_back(n[7:0]);
        if (hi)
        begin
            body_q.push_back(8'h00);
            body_q.push_back(8'($urandom_range(128, 255)));
        end
        else if (vlen > 1)
            body_q.push_back(8'($urandom_range(1, 127)));
        else
            body_q.push_back(8'($urandom_range(0, 127)));
        for (i = 1; i < vlen; i++)
            body_q.push_back(8'($urandom_range(0, 255)));
    endfunction

    function automatic void build_signature(int rlen, bit rhi, int slen, bit shi);
        int i;
        body_q.delete();
        add_integer(rlen, rhi);
        add_integer(slen, shi);
        msg_q.delete();
        msg_q.push_back(TAG_SEQUENCE);
        if (body_q.size() > 127)
            msg_q.push_back(LEN_LONG_1);
        msg_q.push_back(8'(body_q.size()));
        for (i = 0; i < body_q.size(); i++)
            msg_q.push_back(body_q[i]);
    endfunction

    function automatic void corrupt_message();
        int k;
        k = $urandom_range(0, msg_q.size() - 1);
        case ($urandom_range(0, 3))
            0: msg_q[k] = 8'($urandom_range(0, 255));
            1: while (msg_q.size() > k + 1) void'(msg_q.pop_back());
            2: msg_q.push_back(8'($urandom_range(0, 255)));
            default: msg_q[k][$urandom_range(0, 7)] = ~msg_q[k][$urandom_range(0, 7)];
        endcase
    endfunction

    function automatic int pick_len();
        int top;
        top = (size_cfg < 8) ? size_cfg : 8;
        if ($urandom_range(0, 9) < 7)
            return $urandom_range(1, top);
        return $urandom_range(1, size_cfg);
    endfunction

    function automatic logic [7:0] pick_index();
        if (size_cfg >= 1 && size_cfg <= MAX_SCALAR_BYTES && $urandom_range(0, 3) != 0)
            return 8'($urandom_range(0, 2 * size_cfg - 1));
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic void log_failure(string msg);
        if (mismatches < 10)
            $display("%s", msg);
        mismatches++;
    endfunction

    // ---------------------------------------------------------------- drivers

    // called at a falling edge, returns at a falling edge with valid still high
    task automatic send_item(logic op, logic [7:0] b, logic last, logic [7:0] idx);
        int     gap;
        reply_t want;
        if (!no_idle && $urandom_range(0, 99) < 36)
        begin
            gap = $urandom_range(1, 2);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid  <= 1'b1;
        opcode    <= op;
        der_byte  <= b;
        last_byte <= last;
        raw_index <= idx;
        do @(posedge clk); while (!in_ready);
        if (op == OP_READ)
            want = fetch_raw(idx);
        else
            want = decode_push(b, last);
        replies_due.push_back(want);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic push_byte(logic [7:0] b, logic last);
        send_item(OP_PUSH, b, last, 8'($urandom_range(0, 255)));
    endtask

    task automatic read_raw(logic [7:0] idx);
        send_item(OP_READ, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), idx);
    endtask

    task automatic send_message();
        int i;
        for (i = 0; i < msg_q.size(); i++)
            push_byte(msg_q[i], i == msg_q.size() - 1);
    endtask

    task automatic read_some(int n);
        int i;
        for (i = 0; i < n; i++)
            read_raw(pick_index());
    endtask

    // hold the sender until every pending result is back
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (replies_due.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic set_scalar_size(logic [6:0] v);
        wait_drained();
        cfg_valid       <= 1'b1;
        cfg_scalar_size <= v;
        do @(posedge clk); while (!cfg_ready);
        size_cfg = v;
        restart_parse();
        store_ok = 1'b0;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_good_signature();
        int rlen;
        int slen;
        rlen = pick_len();
        slen = pick_len();
        // now and then one scalar is a byte too wide
        if (size_cfg < MAX_SCALAR_BYTES && $urandom_range(0, 19) == 0)
            rlen = size_cfg + 1;
        build_signature(rlen, 1'($urandom_range(0, 1)), slen, 1'($urandom_range(0, 1)));
        send_message();
    endtask

    // ---------------------------------------------------------------- tests

    task automatic test_directed();
        msg_q = '{8'h30, 8'h06, 8'h02, 8'h01, 8'h00, 8'h02, 8'h01, 8'h7F};
        send_message();
        read_raw(8'd31);
        read_raw(8'd63);
        read_raw(8'd0);
        read_raw(8'd255);
        msg_q = '{8'h30, 8'h08, 8'h02, 8'h02, 8'h00, 8'hFF, 8'h02, 8'h02, 8'h00, 8'h80};
        send_message();
        read_raw(8'd31);
        read_raw(8'd63);
        push_byte(8'h31, 1'b1);
        read_raw(8'd63);
    endtask

    task automatic test_error_paths();
        // zero length integer, then more bytes after the failure
        msg_q = '{8'h30, 8'h06, 8'h02, 8'h00, 8'h02, 8'h01, 8'h01};
        send_message();
        // last byte before the integers are complete
        msg_q = '{8'h30, 8'h06, 8'h02, 8'h01, 8'h05};
        send_message();
        // trailing byte after the second integer
        msg_q = '{8'h30, 8'h06, 8'h02, 8'h01, 8'h11, 8'h02, 8'h01, 8'h22, 8'h00};
        send_message();
        // redundant leading zero, negative value, non-minimal long length
        msg_q = '{8'h30, 8'h07, 8'h02, 8'h02, 8'h00, 8'h01, 8'h02, 8'h01, 8'h01};
        send_message();
        msg_q = '{8'h30, 8'h06, 8'h02, 8'h01, 8'h80, 8'h02, 8'h01, 8'h01};
        send_message();
        msg_q = '{8'h30, 8'h81, 8'h06, 8'h02, 8'h01, 8'h01, 8'h02, 8'h01, 8'h01};
        send_message();
        // an accepted store is dropped by the next push
        build_signature(3, 1'b0, 4, 1'b1);
        send_message();
        read_some(3);
        push_byte(8'h30, 1'b0);
        read_raw(8'd31);
        push_byte(8'h00, 1'b1);
        read_raw(8'd31);
    endtask

    task automatic test_config_sweep();
        logic [6:0] sizes[5];
        int         i;
        int         j;
        sizes = '{7'd1, 7'd66, 7'd0, 7'd127, 7'd5};
        for (i = 0; i < 5; i++)
        begin
            set_scalar_size(sizes[i]);
            for (j = 0; j < 3; j++)
            begin
                if (size_cfg >= 1 && size_cfg <= MAX_SCALAR_BYTES)
                    send_good_signature();
                else
                    build_signature(1, 1'b0, 1, 1'b1);
                if (size_cfg >= 1 && size_cfg <= MAX_SCALAR_BYTES)
                    ;
                else
                    send_message();
                read_some(3);
            end
        end
        // widest scalars with the sign pad: needs the long sequence length
        set_scalar_size(7'd66);
        build_signature(66, 1'b1, 66, 1'b1);
        send_message();
        read_raw(8'd0);
        read_raw(8'd65);
        read_raw(8'd131);
        read_raw(8'd132);
        // a register write in the middle of a message restarts the parser
        build_signature(4, 1'b0, 4, 1'b0);
        push_byte(msg_q[0], 1'b0);
        push_byte(msg_q[1], 1'b0);
        push_byte(msg_q[2], 1'b0);
        set_scalar_size(7'd20);
        build_signature(20, 1'b1, 2, 1'b0);
        send_message();
        read_some(4);
    endtask

    task automatic test_backpressure();
        int i;
        wait_drained();
        no_idle      = 1'b1;
        hold_request = HOLD_CYCLES;
        for (i = 0; i < 3; i++)
            send_good_signature();
        read_some(6);
        no_idle = 1'b0;
        wait_drained();
    endtask

    task automatic test_random_traffic();
        int         pick;
        logic [6:0] sizes[6];
        sizes = '{7'd1, 7'd2, 7'd8, 7'd32, 7'd66, 7'd13};
        set_scalar_size(7'd8);
        while (items_sent < ITEM_TARGET)
        begin
            no_idle = items_sent >= 350 && items_sent < 470;
            if ($urandom_range(0, 24) == 0)
            begin
                if ($urandom_range(0, 1) == 0)
                    set_scalar_size(sizes[$urandom_range(0, 5)]);
                else
                    set_scalar_size(7'($urandom_range(1, MAX_SCALAR_BYTES)));
            end
            pick = $urandom_range(0, 99);
            if (pick < 65)
                send_good_signature();
            else if (pick < 85)
            begin
                build_signature(pick_len(), 1'($urandom_range(0, 1)), pick_len(),
                                1'($urandom_range(0, 1)));
                corrupt_message();
                send_message();
            end
            else
            begin
                repeat ($urandom_range(1, 4))
                    push_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            end
            read_some($urandom_range(1, 4));
            if ($urandom_range(0, 15) == 0)
                wait_drained();
        end
        no_idle = 1'b0;
    endtask

    // ---------------------------------------------------------------- receiver and checks

    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request > 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else if (no_idle)
                out_ready <= 1'b1;
            else
                out_ready <= ($urandom_range(0, 99) >= 36);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (replies_due.size() == 0)
                log_failure($sformatf("%0t: result with nothing pending: status %0d raw %02h ok %0b",
                                      $time, status, raw_byte, read_ok));
            else
            begin
                got_want = replies_due.pop_front();
                if (status !== got_want.status || raw_byte !== got_want.raw ||
                    read_ok !== got_want.ok)
                    log_failure($sformatf(
                        "%0t: mismatch exp status %0d raw %02h ok %0b, got status %0d raw %02h ok %0b",
                        $time, got_want.status, got_want.raw, got_want.ok,
                        status, raw_byte, read_ok));
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
            (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ---------------------------------------------------------------- sequence

    initial
    begin
        rst_n           = 1'b0;
        in_valid        = 1'b0;
        opcode          = OP_PUSH;
        der_byte        = 8'h00;
        last_byte       = 1'b0;
        raw_index       = 8'h00;
        cfg_valid       = 1'b0;
        cfg_scalar_size = 7'd32;
        mismatches      = 0;
        items_sent      = 0;
        quiet_cycles    = 0;
        hold_request    = 0;
        hold_left       = 0;
        no_idle         = 1'b0;
        size_cfg        = 32;
        store_ok        = 1'b0;
        restart_parse();
        foreach (raw_mem[i])
            raw_mem[i] = 8'h00;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_directed();
        test_error_paths();
        test_config_sweep();
        test_backpressure();
        test_random_traffic();

        wait_drained();
        repeat (8) @(posedge clk);
        if (mismatches == 0 && replies_due.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
